// ===== rtl/core/oss_pkg.sv =====
// Shared types and codes for the ordered set successor unit.
package oss_pkg;

	localparam int OpBits   = 2;
	localparam int KeyBits  = 17;
	localparam int StatBits = 2;
	localparam int InBytes  = (OpBits + KeyBits + 7) / 8;
	localparam int OutBytes = (StatBits + KeyBits + 7) / 8;

	typedef enum logic [OpBits-1:0] {
		OP_MIN_GE = 2'd0,
		OP_MIN_GT = 2'd1,
		OP_INSERT = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	localparam logic [StatBits-1:0] ST_FOUND = 2'd0;
	localparam logic [StatBits-1:0] ST_NONE  = 2'd1;
	localparam logic [StatBits-1:0] ST_FULL  = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic strict;
		logic shift_ins;
		logic shift_rem;
	} oss_cmd_t;

	typedef struct packed {
		logic               present;
		logic               full;
		logic               found;
		logic [KeyBits-1:0] answer;
	} oss_stat_t;

endpackage

// ===== rtl/core/oss_datapath.sv =====
// Sorted cell array: parallel compare, shift on insert or remove, successor select.
module oss_datapath import oss_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [KeyBits-1:0] key_in,
	input  oss_cmd_t           cmd,
	output oss_stat_t          stat
);

	logic [VALUE_BITS-1:0] ent_q [CAPACITY];
	logic [CAPACITY-1:0]   vld_q;
	logic [CAPACITY-1:0]   lt_q, gt_q, eq_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] key_w;
	logic [CAPACITY-1:0]   sel;
	logic [VALUE_BITS-1:0] ans;

	assign key_w = VALUE_BITS'(key_in);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			gt_q <= '0;
			eq_q <= '0;
		end else if (cmd.load) begin
			for (int i = 0; i < CAPACITY; i++) begin
				lt_q[i] <= vld_q[i] && (ent_q[i] < key_w);
				gt_q[i] <= vld_q[i] && (ent_q[i] > key_w);
				eq_q[i] <= vld_q[i] && (ent_q[i] == key_w);
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  prev_lt, prev_gt, prev_vld, next_vld;
		logic [VALUE_BITS-1:0] prev_ent, next_ent;
		if (i == 0) begin : g_first
			assign prev_lt  = 1'b1;
			assign prev_gt  = 1'b0;
			assign prev_vld = 1'b1;
			assign prev_ent = key_q;
		end else begin : g_mid
			assign prev_lt  = lt_q[i-1];
			assign prev_gt  = gt_q[i-1];
			assign prev_vld = vld_q[i-1];
			assign prev_ent = ent_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_vld = 1'b0;
			assign next_ent = ent_q[i];
		end else begin : g_up
			assign next_vld = vld_q[i+1];
			assign next_ent = ent_q[i+1];
		end

		assign sel[i] = cmd.strict ? (gt_q[i] && !prev_gt)
		                           : (vld_q[i] && !lt_q[i] && prev_lt);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (cmd.shift_ins) begin
				vld_q[i] <= vld_q[i] | prev_vld;
			end else if (cmd.shift_rem && !lt_q[i]) begin
				vld_q[i] <= next_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.shift_ins && !lt_q[i]) begin
				ent_q[i] <= prev_lt ? key_q : prev_ent;
			end else if (cmd.shift_rem && !lt_q[i]) begin
				ent_q[i] <= next_ent;
			end
		end
	end

	always_comb begin
		ans = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			ans = ans | (sel[i] ? ent_q[i] : '0);
		end
	end

	assign stat.present = |eq_q;
	assign stat.full    = vld_q[CAPACITY-1];
	assign stat.found   = |sel;
	assign stat.answer  = KeyBits'(ans);

	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_q >> 1) & ~vld_q) == '0)
		else $error("valid bits not contiguous");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_ins |-> !vld_q[CAPACITY-1])
		else $error("insert shift into full store");
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel))
		else $error("more than one successor selected");

endmodule

// ===== rtl/core/oss_ctrl.sv =====
// Operation sequencer and result register.
module oss_ctrl import oss_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  op_t                 op_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [StatBits-1:0] out_status,
	output logic [KeyBits-1:0]  out_answer,
	output oss_cmd_t            cmd,
	input  oss_stat_t           stat
);

	state_t              state_q, state_d;
	op_t                 op_q;
	logic                emit;
	logic [StatBits-1:0] emit_status;
	logic [KeyBits-1:0]  emit_answer;
	logic                out_free;

	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_in;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.strict    = (op_q == OP_MIN_GT);
		emit          = 1'b0;
		emit_status   = ST_NONE;
		emit_answer   = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_MIN_GE, OP_MIN_GT: begin
						if (out_free) begin
							emit        = 1'b1;
							emit_status = stat.found ? ST_FOUND : ST_NONE;
							emit_answer = stat.found ? stat.answer : '0;
							state_d     = S_IDLE;
						end
					end
					OP_INSERT: begin
						if (stat.present) begin
							state_d = S_IDLE;
						end else if (!stat.full) begin
							cmd.shift_ins = 1'b1;
							state_d       = S_IDLE;
						end else if (out_free) begin
							emit        = 1'b1;
							emit_status = ST_FULL;
							state_d     = S_IDLE;
						end
					end
					OP_REMOVE: begin
						cmd.shift_rem = stat.present;
						state_d       = S_IDLE;
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status <= emit_status;
			out_answer <= emit_answer;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_EXEC)
		else $error("accepted item not executed");
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> state_q == S_EXEC && out_free)
		else $error("result written outside execute or over pending result");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_ins && cmd.shift_rem))
		else $error("insert and remove at once");

endmodule

// ===== rtl/core/ordered_set_successor_unit.sv =====
// Top level of the ordered set successor unit.
//  channel | dir | fields (low bit up)
//  s_*     | in  | tdata: operation[1:0], key_value[18:2]
//  m_*     | out | tdata: status[1:0], answer_value[18:2]
// Each item is accepted with a compare of all cells, then shifts or selects in the execute state.
// Result path: select is an OR over all cells of the one-hot successor.
// Reset clears the valid bits; stored values need no clearing.
// A result held on m_* stalls the next query or full insert in its execute cycle.
module ordered_set_successor_unit import oss_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int VALUE_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [InBytes*8-1:0]  s_tdata,  // operation, key_value
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OutBytes*8-1:0] m_tdata   // status, answer_value
);

	oss_cmd_t            cmd;
	oss_stat_t           stat;
	logic [StatBits-1:0] status;
	logic [KeyBits-1:0]  answer_value;

	oss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.op_in      (op_t'(s_tdata[OpBits-1:0])),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (status),
		.out_answer (answer_value),
		.cmd        (cmd),
		.stat       (stat)
	);

	oss_datapath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (s_tdata[OpBits+KeyBits-1:OpBits]),
		.cmd    (cmd),
		.stat   (stat)
	);

	assign m_tdata = {{(OutBytes*8-StatBits-KeyBits){1'b0}}, answer_value, status};

endmodule
